FILE: design/implicit_heat_slab_step_core_macros.svh
// Assertion helpers for the slab step core.
`ifndef IMPLICIT_HEAT_SLAB_STEP_CORE_MACROS_SVH
`define IMPLICIT_HEAT_SLAB_STEP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define IHS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
`define IHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define IHS_ASSERT_IMPL(lbl, ante, cons)
`define IHS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/ihs_pkg.sv
package ihs_pkg;

  // intermediate values live in +-2^60
  typedef logic signed [61:0] wide_t;

  localparam wide_t LIM = 62'sd1152921504606846976;
  localparam wide_t ONE = 62'sd65536;

  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_STEP = 2'd1;

  localparam logic [1:0] MODE_FIXED = 2'd0;
  localparam logic [1:0] MODE_FLUX  = 2'd1;

  localparam logic [2:0] REG_STEP_RATIO   = 3'd0;
  localparam logic [2:0] REG_LEFT_MODE    = 3'd1;
  localparam logic [2:0] REG_LEFT_VALUE   = 3'd2;
  localparam logic [2:0] REG_LEFT_BIOT    = 3'd3;
  localparam logic [2:0] REG_RIGHT_MODE   = 3'd4;
  localparam logic [2:0] REG_RIGHT_VALUE  = 3'd5;
  localparam logic [2:0] REG_RIGHT_BIOT   = 3'd6;
  localparam logic [2:0] REG_INITIAL_TEMP = 3'd7;

  function automatic wide_t clampw(input logic signed [63:0] v);
    logic signed [63:0] lim64;
    lim64 = 64'(LIM);
    if (v > lim64) return LIM;
    if (v < -lim64) return -LIM;
    return 62'(v);
  endfunction

  function automatic wide_t addw(input wide_t a, input wide_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    return clampw(s);
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > 62'sd2147483647) return 32'sh7fffffff;
    if (v < -62'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic logic [60:0] mag61(input wide_t v);
    return v[61] ? 61'(-v) : 61'(v);
  endfunction

endpackage

FILE: design/ihs_ram.sv
module ihs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: design/ihs_mul.sv
module ihs_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ihs_pkg::wide_t a_i,
  input  ihs_pkg::wide_t b_i,
  output logic          done_o,
  output ihs_pkg::wide_t res_o
);
  import ihs_pkg::*;

  logic         busy_q, fin_q;
  logic [1:0]   cnt_q;
  logic [60:0]  am_q;
  logic [63:0]  bm_q;
  logic [124:0] acc_q;
  logic         neg_q;
  logic [76:0]  part;
  logic [60:0]  mag;

  // 61 x 16 partial product per cycle, top chunk first
  assign part = {16'b0, am_q} * {61'b0, bm_q[63:48]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= mag61(a_i);
      bm_q  <= {3'b0, mag61(b_i)};
      acc_q <= '0;
      neg_q <= a_i[61] ^ b_i[61];
    end else if (busy_q) begin
      acc_q <= {acc_q[108:0], 16'b0} + {48'b0, part};
      bm_q  <= {bm_q[47:0], 16'b0};
    end
  end

  // a product that overflows 64 bits saturates to the limit
  assign mag    = (|acc_q[124:64]) ? 61'(LIM) : acc_q[76:16];
  assign res_o  = neg_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign done_o = fin_q;
endmodule

FILE: design/ihs_div.sv
module ihs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ihs_pkg::wide_t     n_i,
  input  ihs_pkg::wide_t     d_i,
  output logic               done_o,
  output logic signed [31:0] q_o
);
  import ihs_pkg::*;

  logic        busy_q, fin_q;
  logic [4:0]  cnt_q;
  logic [60:0] rem_q, dm_q, nm;
  logic [30:0] sh_q, quo_q;
  logic        neg_q, zn_q, ovf_q;
  logic [61:0] trial;
  logic        ge;

  assign nm    = mag61(n_i);
  assign trial = {rem_q, sh_q[30]};
  assign ge    = trial >= {1'b0, dm_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd30) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dm_q  <= mag61(d_i);
      zn_q  <= (n_i == '0);
      neg_q <= n_i[61] ^ d_i[61];
      // integer part of the quotient must stay below 2^15; covers a zero divisor
      ovf_q <= {15'b0, nm} >= {mag61(d_i), 15'b0};
      rem_q <= {15'b0, nm[60:15]};
      sh_q  <= {nm[14:0], 16'b0};
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 61'(trial - {1'b0, dm_q}) : 61'(trial);
      quo_q <= {quo_q[29:0], ge};
      sh_q  <= {sh_q[29:0], 1'b0};
    end
  end

  always_comb begin
    if (zn_q) begin
      q_o = '0;
    end else if (ovf_q) begin
      q_o = neg_q ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      q_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    end
  end

  assign done_o = fin_q;
endmodule

FILE: design/implicit_heat_slab_step_core.sv
// Implicit heat-conduction step engine for a 1-D slab of NODES points.
// Configuration: APB-style port, registers at byte addresses 0..28 (step
// ratio, left mode/value/biot, right mode/value/biot, initial temperature).
// Write configuration only while busy is low.
// Commands: pulse start with operation_i and node_index_i while busy is low.
// init fills the profile, step runs one Thomas sweep, read only reads.
// Every command returns one result: done_o high for one cycle with the
// addressed node temperature (0 beyond the grid) and node_echo_o.
// The step duration varies with the boundary modes. The forward pass
// dominates: per node two multiplies and one divide, with the alpha and
// beta dividers in parallel; back substitution reads, captures and
// multiplies once per node.
// One command at a time; busy stays high until done_o, and the next request
// is accepted in the cycle after the result at the earliest.
// Reset: registers to defaults, profile reads as zero until the first
// init or step completes (no clearing pass). The receiver cannot stall.
module implicit_heat_slab_step_core #(
  parameter int NODES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation_i,
  input  logic [5:0]         node_index_i,
  output logic               done_o,
  output logic signed [31:0] temperature_o,
  output logic [5:0]         node_echo_o
);
  import ihs_pkg::*;

  `include "implicit_heat_slab_step_core_macros.svh"

  localparam int AW = $clog2(NODES);
  localparam logic [AW-1:0] LastNode = AW'(NODES - 1);

  typedef enum logic [17:0] {
    ST_IDLE    = 18'h00001,
    ST_INIT    = 18'h00002,
    ST_LOAD    = 18'h00004,
    ST_CAP     = 18'h00008,
    ST_LB_M1   = 18'h00010,
    ST_LB_M2   = 18'h00020,
    ST_LB_M3   = 18'h00040,
    ST_FW_M1   = 18'h00080,
    ST_FW_M2   = 18'h00100,
    ST_DIV     = 18'h00200,
    ST_RB_M1   = 18'h00400,
    ST_RB_M2   = 18'h00800,
    ST_RB_M3   = 18'h01000,
    ST_BK_LOAD = 18'h02000,
    ST_BK_CAP  = 18'h04000,
    ST_BK_MUL  = 18'h08000,
    ST_RD      = 18'h10000,
    ST_RESP    = 18'h20000
  } state_e;

  // configuration
  logic [31:0]        step_ratio_q, left_biot_q, right_biot_q;
  logic [1:0]         left_mode_q, right_mode_q;
  logic signed [31:0] left_value_q, right_value_q, initial_temp_q;

  state_e             state_q, state_d;
  logic               issued_q, issued_d;
  logic               valid_q, valid_d;
  logic [AW-1:0]      i_q, i_d;
  logic [5:0]         idx_q, idx_d;
  wide_t              a_q, a_d, b_q, b_d, p_q, p_d, tmp_q, tmp_d;
  wide_t              num_q, num_d, den_q, den_d;
  logic signed [31:0] t_q, t_d;

  logic               prof_we, prof_re, ab_we, ab_re;
  logic [AW-1:0]      prof_wa, prof_ra;
  logic [31:0]        prof_wd, prof_rd;
  logic [63:0]        ab_wd, ab_rd;

  logic               mul_start, mul_done, div_start, div_a_done, div_b_done;
  wide_t              mul_a, mul_b, mul_res, div_a_n;
  logic signed [31:0] qa, qb, bk_t;

  wide_t r, r2, lv, lb, rv, rb;
  logic  left_flux, right_flux, idx_ok;

  assign r          = $signed({30'b0, step_ratio_q});
  assign r2         = r <<< 1;
  assign lv         = wide_t'(left_value_q);
  assign rv         = wide_t'(right_value_q);
  assign lb         = $signed({30'b0, left_biot_q});
  assign rb         = $signed({30'b0, right_biot_q});
  assign left_flux  = (left_mode_q == MODE_FLUX);
  assign right_flux = (right_mode_q == MODE_FLUX);
  assign idx_ok     = ({26'b0, idx_q} < 32'(NODES));

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ratio_q   <= 32'h00010000;
      left_mode_q    <= MODE_FIXED;
      left_value_q   <= '0;
      left_biot_q    <= '0;
      right_mode_q   <= MODE_FIXED;
      right_value_q  <= '0;
      right_biot_q   <= '0;
      initial_temp_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_STEP_RATIO:   step_ratio_q   <= pwdata;
        REG_LEFT_MODE:    left_mode_q    <= pwdata[1:0];
        REG_LEFT_VALUE:   left_value_q   <= pwdata;
        REG_LEFT_BIOT:    left_biot_q    <= pwdata;
        REG_RIGHT_MODE:   right_mode_q   <= pwdata[1:0];
        REG_RIGHT_VALUE:  right_value_q  <= pwdata;
        REG_RIGHT_BIOT:   right_biot_q   <= pwdata;
        REG_INITIAL_TEMP: initial_temp_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_STEP_RATIO:   prdata = step_ratio_q;
      REG_LEFT_MODE:    prdata = {30'b0, left_mode_q};
      REG_LEFT_VALUE:   prdata = left_value_q;
      REG_LEFT_BIOT:    prdata = left_biot_q;
      REG_RIGHT_MODE:   prdata = {30'b0, right_mode_q};
      REG_RIGHT_VALUE:  prdata = right_value_q;
      REG_RIGHT_BIOT:   prdata = right_biot_q;
      REG_INITIAL_TEMP: prdata = initial_temp_q;
      default:          prdata = '0;
    endcase
  end

  // multiplier operand select
  always_comb begin
    case (state_q)
      ST_LB_M1: begin mul_a = r2; mul_b = lb; end
      ST_LB_M2: begin mul_a = left_flux ? r2 : tmp_q; mul_b = lv; end
      ST_LB_M3: begin mul_a = r2; mul_b = addw(ONE, lb); end
      ST_FW_M1: begin mul_a = r; mul_b = a_q; end
      ST_FW_M2: begin mul_a = r; mul_b = b_q; end
      ST_RB_M1: begin
        mul_a = right_flux ? r2 : rb;
        mul_b = right_flux ? b_q : rv;
      end
      ST_RB_M2: begin
        mul_a = r2;
        mul_b = right_flux ? rv : addw(b_q, tmp_q);
      end
      ST_RB_M3: begin
        mul_a = r2;
        mul_b = right_flux ? addw(ONE, -a_q) : addw(addw(ONE, -a_q), rb);
      end
      ST_BK_MUL: begin mul_a = a_q; mul_b = wide_t'(t_q); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign div_a_n = (i_q == '0) ? r2 : r;
  assign bk_t    = sat32(addw(mul_res, b_q));

  always_comb begin
    state_d   = state_q;
    issued_d  = issued_q;
    valid_d   = valid_q;
    i_d       = i_q;
    idx_d     = idx_q;
    a_d       = a_q;
    b_d       = b_q;
    p_d       = p_q;
    tmp_d     = tmp_q;
    num_d     = num_q;
    den_d     = den_q;
    t_d       = t_q;
    prof_we   = 1'b0;
    prof_wa   = i_q;
    prof_wd   = t_q;
    prof_re   = 1'b0;
    prof_ra   = i_q;
    ab_we     = 1'b0;
    ab_wd     = {qa, qb};
    ab_re     = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          idx_d = node_index_i;
          i_d   = '0;
          case (operation_i)
            OP_INIT: state_d = ST_INIT;
            OP_STEP: state_d = ST_LOAD;
            default: state_d = ST_RD;
          endcase
        end
      end
      ST_INIT: begin
        prof_we = 1'b1;
        prof_wd = initial_temp_q;
        if (i_q == LastNode) begin
          valid_d = 1'b1;
          state_d = ST_RD;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_LOAD: begin
        prof_re = 1'b1;
        state_d = ST_CAP;
      end
      ST_CAP: begin
        p_d = valid_q ? wide_t'($signed(prof_rd)) : '0;
        if (i_q == '0) begin
          case (left_mode_q)
            MODE_FIXED: begin
              a_d     = '0;
              b_d     = lv;
              ab_we   = 1'b1;
              ab_wd   = {32'b0, left_value_q};
              i_d     = i_q + 1'b1;
              state_d = ST_LOAD;
            end
            MODE_FLUX: state_d = ST_LB_M2;
            default:   state_d = ST_LB_M1;
          endcase
        end else if (i_q == LastNode) begin
          if (right_mode_q == MODE_FIXED) begin
            t_d     = right_value_q;
            prof_we = 1'b1;
            prof_wd = right_value_q;
            i_d     = i_q - 1'b1;
            state_d = ST_BK_LOAD;
          end else begin
            state_d = ST_RB_M1;
          end
        end else begin
          state_d = ST_FW_M1;
        end
      end
      ST_LB_M1, ST_LB_M2, ST_LB_M3, ST_FW_M1, ST_FW_M2,
      ST_RB_M1, ST_RB_M2, ST_RB_M3, ST_BK_MUL: begin
        mul_start = !issued_q;
        issued_d  = 1'b1;
        if (mul_done) begin
          issued_d = 1'b0;
          case (state_q)
            ST_LB_M1: begin
              tmp_d   = mul_res;
              state_d = ST_LB_M2;
            end
            ST_LB_M2: begin
              num_d = addw(p_q, mul_res);
              if (left_flux) begin
                den_d   = addw(r2, ONE);
                state_d = ST_DIV;
              end else begin
                state_d = ST_LB_M3;
              end
            end
            ST_LB_M3: begin
              den_d   = addw(mul_res, ONE);
              state_d = ST_DIV;
            end
            ST_FW_M1: begin
              den_d   = addw(addw(r2, ONE), -mul_res);
              state_d = ST_FW_M2;
            end
            ST_FW_M2: begin
              num_d   = addw(mul_res, p_q);
              state_d = ST_DIV;
            end
            ST_RB_M1: begin
              tmp_d   = mul_res;
              state_d = ST_RB_M2;
            end
            ST_RB_M2: begin
              num_d   = right_flux ? addw(addw(tmp_q, -mul_res), p_q)
                                   : addw(p_q, mul_res);
              state_d = ST_RB_M3;
            end
            ST_RB_M3: begin
              den_d   = addw(ONE, mul_res);
              state_d = ST_DIV;
            end
            default: begin
              // back substitution
              t_d     = bk_t;
              prof_we = 1'b1;
              prof_wd = bk_t;
              if (i_q == '0) begin
                valid_d = 1'b1;
                state_d = ST_RD;
              end else begin
                i_d     = i_q - 1'b1;
                state_d = ST_BK_LOAD;
              end
            end
          endcase
        end
      end
      ST_DIV: begin
        div_start = !issued_q;
        issued_d  = 1'b1;
        if (div_b_done) begin
          issued_d = 1'b0;
          if (i_q == LastNode) begin
            t_d     = qb;
            prof_we = 1'b1;
            prof_wd = qb;
            i_d     = i_q - 1'b1;
            state_d = ST_BK_LOAD;
          end else begin
            a_d     = wide_t'(qa);
            b_d     = wide_t'(qb);
            ab_we   = 1'b1;
            i_d     = i_q + 1'b1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_BK_LOAD: begin
        ab_re   = 1'b1;
        state_d = ST_BK_CAP;
      end
      ST_BK_CAP: begin
        a_d     = wide_t'($signed(ab_rd[63:32]));
        b_d     = wide_t'($signed(ab_rd[31:0]));
        state_d = ST_BK_MUL;
      end
      ST_RD: begin
        prof_re = 1'b1;
        prof_ra = AW'(idx_q);
        state_d = ST_RESP;
      end
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      valid_q  <= 1'b0;
      i_q      <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      valid_q  <= valid_d;
      i_q      <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    a_q   <= a_d;
    b_q   <= b_d;
    p_q   <= p_d;
    tmp_q <= tmp_d;
    num_q <= num_d;
    den_q <= den_d;
    t_q   <= t_d;
  end

  ihs_ram #(.WIDTH(32), .DEPTH(NODES)) u_profile (
    .clk_i   (clk_i),
    .we_i    (prof_we),
    .waddr_i (prof_wa),
    .wdata_i (prof_wd),
    .re_i    (prof_re),
    .raddr_i (prof_ra),
    .rdata_o (prof_rd)
  );

  // alpha in the upper half, beta in the lower
  ihs_ram #(.WIDTH(64), .DEPTH(NODES)) u_sweep (
    .clk_i   (clk_i),
    .we_i    (ab_we),
    .waddr_i (i_q),
    .wdata_i (ab_wd),
    .re_i    (ab_re),
    .raddr_i (i_q),
    .rdata_o (ab_rd)
  );

  ihs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  ihs_div u_div_alpha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (div_a_n),
    .d_i     (den_q),
    .done_o  (div_a_done),
    .q_o     (qa)
  );

  ihs_div u_div_beta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (num_q),
    .d_i     (den_q),
    .done_o  (div_b_done),
    .q_o     (qb)
  );

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = (state_q == ST_RESP);
  assign temperature_o = (valid_q && idx_ok) ? $signed(prof_rd) : '0;
  assign node_echo_o   = idx_q;

  `IHS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `IHS_ASSERT_NEXT(a_done_idle, done_o, !busy)
  `IHS_ASSERT_IMPL(a_index_range, busy, i_q <= LastNode)
  `IHS_ASSERT_IMPL(a_div_lockstep, div_b_done, div_a_done)
endmodule
